// File: design/iacl_pkg.sv
// Shared types, codes and helper functions for the IPv4 allow/deny rule matcher.
// No dependencies; used by every module of the block.
package iacl_pkg;

  // Table geometry
  localparam int RULES = 16;
  localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CNT_W = $clog2(RULES + 1);

  // Fixed field widths of the ports
  localparam int MATCH_W = 4;
  localparam int TOT_W   = 5;
  localparam int TOT_MAX = 31;
  localparam int PADDR_W = 4;

  // Register map (word index, byte address = 4 * index)
  localparam logic [1:0] REG_SECURITY = 2'd0;
  localparam logic [1:0] REG_PRESENT  = 2'd1;
  localparam logic [1:0] REG_COUNT    = 2'd2;

  // Rule kind codes
  localparam logic [1:0] KIND_ALLOW = 2'd1;
  localparam logic [1:0] KIND_DENY  = 2'd2;

  // Rule direction codes
  localparam logic [1:0] DIR_NONE    = 2'd0;
  localparam logic [1:0] DIR_PLAY    = 2'd1;
  localparam logic [1:0] DIR_PUBLISH = 2'd2;

  // Rule pattern codes
  localparam logic [1:0] PAT_ALL = 2'd0;
  localparam logic [1:0] PAT_NET = 2'd1;

  // Connection types
  localparam logic [2:0] CONN_PLAY        = 3'd1;
  localparam logic [2:0] CONN_ENC_PUBLISH = 3'd2;
  localparam logic [2:0] CONN_FL_PUBLISH  = 3'd3;
  localparam logic [2:0] CONN_SRT_PUBLISH = 3'd4;

  // Verdict codes
  localparam logic [1:0] VERDICT_ALLOWED        = 2'd0;
  localparam logic [1:0] VERDICT_DEFAULT_DENIED = 2'd1;
  localparam logic [1:0] VERDICT_RULE_DENIED    = 2'd2;
  localparam logic [1:0] VERDICT_NOT_ALLOWED    = 2'd3;

  // One stored rule; address is kept pre-masked with its prefix mask
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  direction;
    logic [1:0]  pattern;
    logic [31:0] net;
    logic [31:0] mask;
  } rule_t;

  // Check fields held in the input register
  typedef struct packed {
    logic        action;
    logic [2:0]  conn_type;
    logic [31:0] client_addr;
  } item_t;

  // Configuration registers
  typedef struct packed {
    logic       security_enabled;
    logic       rules_present;
    logic [4:0] rule_count;
  } cfg_t;

  // One result
  typedef struct packed {
    logic [1:0]         verdict;
    logic [MATCH_W-1:0] matched_rule;
    logic [TOT_W-1:0]   allow_rule_total;
    logic [TOT_W-1:0]   deny_rule_total;
  } result_t;

  // Prefix length to network mask; lengths above 32 act as /32
  function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
    logic [31:0] m;
    if (plen == 6'd0) begin
      m = 32'h0;
    end else if (plen >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> plen[4:0]);
    end
    return m;
  endfunction

  // Connection type to rule direction
  function automatic logic [1:0] conn_dir(input logic [2:0] conn);
    logic [1:0] d;
    case (conn)
      CONN_PLAY:        d = DIR_PLAY;
      CONN_ENC_PUBLISH: d = DIR_PUBLISH;
      CONN_FL_PUBLISH:  d = DIR_PUBLISH;
      CONN_SRT_PUBLISH: d = DIR_PUBLISH;
      default:          d = DIR_NONE;
    endcase
    return d;
  endfunction

  // Index of the lowest set bit (0 when none is set)
  function automatic logic [IDX_W-1:0] first_set(input logic [RULES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = RULES - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  // Number of set bits
  function automatic logic [CNT_W-1:0] ones(input logic [RULES-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < RULES; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

  // Count to port width, saturating
  function automatic logic [TOT_W-1:0] sat_total(input logic [CNT_W-1:0] c);
    logic [TOT_W-1:0] t;
    if (int'(c) > TOT_MAX) t = TOT_W'(TOT_MAX);
    else t = TOT_W'(c);
    return t;
  endfunction

endpackage

// File: design/iacl_rule_table.sv
// Rule storage: one flop row per rule, written on accept of a write item.
// Depends on iacl_pkg (rule_t, prefix_mask).
module iacl_rule_table (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [3:0]                           rule_index,
  input  logic [1:0]                           rule_kind,
  input  logic [1:0]                           rule_direction,
  input  logic [1:0]                           rule_pattern,
  input  logic [31:0]                          rule_addr,
  input  logic [5:0]                           rule_prefix_len,
  output iacl_pkg::rule_t [iacl_pkg::RULES-1:0] entries
);

  iacl_pkg::rule_t wr_entry;
  logic            in_table;

  // Build the stored form: mask from prefix, address pre-masked
  always_comb begin
    wr_entry.kind      = rule_kind;
    wr_entry.direction = rule_direction;
    wr_entry.pattern   = rule_pattern;
    wr_entry.mask      = iacl_pkg::prefix_mask(rule_prefix_len);
    wr_entry.net       = rule_addr & wr_entry.mask;
  end

  // Writes beyond the table are dropped
  assign in_table = int'(rule_index) < iacl_pkg::RULES;

  // Table rows, no reset (undefined until written)
  always_ff @(posedge clk) begin
    for (int i = 0; i < iacl_pkg::RULES; i++) begin
      if (we && in_table && int'(rule_index) == i) begin
        entries[i] <= wr_entry;
      end
    end
  end

endmodule

// File: design/iacl_match.sv
// Single-pass rule evaluation: per-rule compare, deny/allow priority, totals.
// Depends on iacl_pkg (rule_t, item_t, cfg_t, result_t, helpers).
module iacl_match (
  input  iacl_pkg::rule_t [iacl_pkg::RULES-1:0] entries,
  input  iacl_pkg::item_t                       item,
  input  iacl_pkg::cfg_t                        cfg,
  output iacl_pkg::result_t                     result
);

  logic [iacl_pkg::RULES-1:0] in_use;
  logic [iacl_pkg::RULES-1:0] is_allow;
  logic [iacl_pkg::RULES-1:0] is_deny;
  logic [iacl_pkg::RULES-1:0] hit;
  logic [iacl_pkg::RULES-1:0] deny_hit;
  logic [iacl_pkg::RULES-1:0] allow_hit;
  logic [1:0]                 dir;
  logic [iacl_pkg::CNT_W-1:0] allows;
  logic [iacl_pkg::CNT_W-1:0] denies;

  assign dir = iacl_pkg::conn_dir(item.conn_type);

  // Per-rule compare, all rules side by side
  always_comb begin
    for (int i = 0; i < iacl_pkg::RULES; i++) begin
      in_use[i]   = int'(cfg.rule_count) > i;
      is_allow[i] = in_use[i] && (entries[i].kind == iacl_pkg::KIND_ALLOW);
      is_deny[i]  = in_use[i] && (entries[i].kind == iacl_pkg::KIND_DENY);
      hit[i]      = (dir != iacl_pkg::DIR_NONE) && (entries[i].direction == dir) &&
                    ((entries[i].pattern == iacl_pkg::PAT_ALL) ||
                     ((entries[i].pattern == iacl_pkg::PAT_NET) &&
                      ((item.client_addr & entries[i].mask) == entries[i].net)));
    end
  end

  assign deny_hit  = is_deny & hit;
  assign allow_hit = is_allow & hit;
  assign allows    = iacl_pkg::ones(is_allow);
  assign denies    = iacl_pkg::ones(is_deny);

  // Verdict: deny first, then allow, then fallback
  always_comb begin
    result.verdict          = iacl_pkg::VERDICT_ALLOWED;
    result.matched_rule     = '0;
    result.allow_rule_total = iacl_pkg::sat_total(allows);
    result.deny_rule_total  = iacl_pkg::sat_total(denies);
    if (!item.action && cfg.security_enabled) begin
      if (!cfg.rules_present) begin
        result.verdict = iacl_pkg::VERDICT_DEFAULT_DENIED;
      end else if (|deny_hit) begin
        result.verdict      = iacl_pkg::VERDICT_RULE_DENIED;
        result.matched_rule = iacl_pkg::MATCH_W'(iacl_pkg::first_set(deny_hit));
      end else if (|allow_hit) begin
        result.verdict      = iacl_pkg::VERDICT_ALLOWED;
        result.matched_rule = iacl_pkg::MATCH_W'(iacl_pkg::first_set(allow_hit));
      end else if ((|is_allow) || !(|is_deny)) begin
        result.verdict = iacl_pkg::VERDICT_NOT_ALLOWED;
      end
    end
  end

endmodule

// File: design/ipv4_allow_deny_rule_matcher.sv
// Top level of the IPv4 allow/deny rule matcher: APB registers, input and result registers.
// Depends on iacl_pkg, iacl_rule_table and iacl_match.
//
// One item (rule write or connection check) is taken per clock: busy never rises.
// An item accepted at one edge passes through the input register and then the result
// register around the single-pass compare of all 16 rules; its result then shows on the
// result ports, with done high, for one cycle. done cannot be held off, so the
// receiver must take each result in that cycle. A rule write updates the table at its
// accept edge, and its result carries the totals after the write.
// Registers: 0x0 security_enabled, 0x4 rules_present, 0x8 rule_count; change them only
// while no item is in flight.
module ipv4_allow_deny_rule_matcher (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           action,
  input  logic [2:0]                     conn_type,
  input  logic [31:0]                    client_addr,
  input  logic [3:0]                     rule_index,
  input  logic [1:0]                     rule_kind,
  input  logic [1:0]                     rule_direction,
  input  logic [1:0]                     rule_pattern,
  input  logic [31:0]                    rule_addr,
  input  logic [5:0]                     rule_prefix_len,
  // result channel
  output logic                           done,
  output logic [1:0]                     verdict,
  output logic [iacl_pkg::MATCH_W-1:0]   matched_rule,
  output logic [iacl_pkg::TOT_W-1:0]     allow_rule_total,
  output logic [iacl_pkg::TOT_W-1:0]     deny_rule_total,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [iacl_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  iacl_pkg::cfg_t                        cfg;
  iacl_pkg::item_t                       item;
  iacl_pkg::result_t                     res_next;
  iacl_pkg::result_t                     res;
  iacl_pkg::rule_t [iacl_pkg::RULES-1:0] entries;
  logic                                  pend;
  logic                                  accept;
  logic                                  cfg_wr;
  logic [1:0]                            reg_sel;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // Configuration registers
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        iacl_pkg::REG_SECURITY: cfg.security_enabled <= pwdata[0];
        iacl_pkg::REG_PRESENT:  cfg.rules_present    <= pwdata[0];
        iacl_pkg::REG_COUNT:    cfg.rule_count       <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      iacl_pkg::REG_SECURITY: prdata = {31'b0, cfg.security_enabled};
      iacl_pkg::REG_PRESENT:  prdata = {31'b0, cfg.rules_present};
      iacl_pkg::REG_COUNT:    prdata = {27'b0, cfg.rule_count};
      default:                prdata = 32'b0;
    endcase
  end

  // Rule table, written on accept
  iacl_rule_table u_table (
    .clk            (clk),
    .we             (accept && action),
    .rule_index     (rule_index),
    .rule_kind      (rule_kind),
    .rule_direction (rule_direction),
    .rule_pattern   (rule_pattern),
    .rule_addr      (rule_addr),
    .rule_prefix_len(rule_prefix_len),
    .entries        (entries)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.action      <= action;
      item.conn_type   <= conn_type;
      item.client_addr <= client_addr;
    end
  end

  // Evaluation
  iacl_match u_match (
    .entries(entries),
    .item   (item),
    .cfg    (cfg),
    .result (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      res <= res_next;
    end
  end

  assign verdict          = res.verdict;
  assign matched_rule     = res.matched_rule;
  assign allow_rule_total = res.allow_rule_total;
  assign deny_rule_total  = res.deny_rule_total;

`ifndef SYNTHESIS
  // Every accepted item yields a result strobe after the input and result registers
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("accepted item produced no result");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pend))
    else $error("result strobe without an item in flight");

  // With security off every result is allowed with no deciding rule
  a_disabled_allows: assert property (@(posedge clk) disable iff (rst)
    (done && !cfg.security_enabled) |->
      (verdict == iacl_pkg::VERDICT_ALLOWED && matched_rule == '0))
    else $error("disabled matcher reported a denial");

  // A rule denial needs at least one deny rule in use
  a_deny_has_rule: assert property (@(posedge clk) disable iff (rst)
    (done && verdict == iacl_pkg::VERDICT_RULE_DENIED) |-> (deny_rule_total != '0))
    else $error("rule denial with no deny rule counted");
`endif

endmodule
